/* sv/wis_pkg.sv */
package wis_pkg;

    // Fixed field widths
    localparam int SUM_W  = 24;
    localparam int PCT_W  = 7;
    localparam int WIN_W  = 16;
    localparam int TSEL_W = 2;
    localparam int STAT_W = 2;
    localparam int EIDX_W = 8;
    localparam int CIDX_W = 2;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int NUM_TABLES_DEF  = 3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NODROP = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    // No-drop register indexes
    localparam int NUM_REGS = 3;
    localparam logic [CIDX_W-1:0] REG_ND_MATERIAL   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ND_CONSUMABLE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ND_WEAPON     = 2'd2;

    // Request types
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_DRAW   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic eval;     // decide append / draw checks, start search
        logic step;     // one bisect step
        logic load;     // move staged result into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_search;
        logic search_last;
    } sts_t;

endpackage

/* sv/wis_ctrl.sv */
module wis_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  wis_pkg::sts_t sts,
    output wis_pkg::cmd_t cmd
);
    import wis_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.need_search ? S_SRCH : S_DONE;
            end
            S_SRCH:
            begin
                cmd.step = 1'b1;
                if (sts.search_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* sv/wis_dp.sv */
module wis_dp #(
    parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF,
    parameter int NUM_TABLES  = wis_pkg::NUM_TABLES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wis_pkg::cmd_t               cmd,
    output wis_pkg::sts_t               sts,
    input  logic                        req_type,
    input  logic [wis_pkg::TSEL_W-1:0]  table_select,
    input  logic [wis_pkg::WIN_W-1:0]   new_weight,
    input  logic [wis_pkg::PCT_W-1:0]   roll_percent,
    input  logic [wis_pkg::SUM_W-1:0]   pick_value,
    input  logic                        cfg_we,
    input  logic [wis_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [wis_pkg::PCT_W-1:0]   cfg_data,
    output logic [wis_pkg::STAT_W-1:0]  status,
    output logic [wis_pkg::EIDX_W-1:0]  entry_index,
    output logic [wis_pkg::SUM_W-1:0]   total_weight
);
    import wis_pkg::*;

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int ADDR_W    = TBL_W + IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int EXT_W     = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;
    localparam logic [WIN_W-1:0] WMASK = (WEIGHT_BITS >= WIN_W) ? {WIN_W{1'b1}} :
                                         WIN_W'((32'd1 << WEIGHT_BITS) - 32'd1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

    // Running sums memory, one port each way
    logic [SUM_W-1:0]  sums_mem [MEM_DEPTH];
    logic [SUM_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Per-table state and no-drop registers
    logic [CNT_W-1:0]  cnt_reg [NUM_TABLES];
    logic [SUM_W-1:0]  tot_reg [NUM_TABLES];
    logic [PCT_W-1:0]  nd_reg  [NUM_REGS];

    // Captured item
    logic              req_reg;
    logic [TSEL_W-1:0] tsel_reg;
    logic              tbl_ok_reg;
    logic [TBL_W-1:0]  tidx_reg;
    logic [WIN_W-1:0]  weight_reg;
    logic [PCT_W-1:0]  roll_reg;
    logic [SUM_W-1:0]  pick_reg;

    // Search state
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [IDX_W-1:0]  mid_reg;

    // Staged result and output register
    logic [STAT_W-1:0] res_status_reg;
    logic [IDX_W-1:0]  res_index_reg;
    logic [SUM_W-1:0]  res_total_reg;
    logic [STAT_W-1:0] status_reg;
    logic [EIDX_W-1:0] index_reg;
    logic [SUM_W-1:0]  total_reg;

    logic [2:0]        tsel_ext;
    logic              tbl_ok_in;
    logic [CNT_W-1:0]  n_cur;
    logic [SUM_W-1:0]  tot_cur;
    logic [PCT_W-1:0]  nd_cur;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;
    logic              full;
    logic              app_go;
    logic              draw_go;
    logic [CNT_W-1:0]  mid_first_full;
    logic [IDX_W-1:0]  mid_first;
    logic              rd_gt;
    logic [CNT_W-1:0]  mid_inc;
    logic [CNT_W-1:0]  lo_n;
    logic [CNT_W-1:0]  hi_n;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid_n_full;
    logic [IDX_W-1:0]  rd_mid;
    logic [STAT_W-1:0] ev_status;
    logic [SUM_W-1:0]  ev_total;
    logic [EXT_W-1:0]  idx_ext;

    // Table select decode
    assign tsel_ext  = {1'b0, table_select};
    assign tbl_ok_in = (32'(table_select) < NUM_TABLES);

    // Current table view
    assign n_cur   = cnt_reg[tidx_reg];
    assign tot_cur = tot_reg[tidx_reg];

    always_comb
    begin
        case (tsel_reg)
            REG_ND_MATERIAL:   nd_cur = nd_reg[REG_ND_MATERIAL];
            REG_ND_CONSUMABLE: nd_cur = nd_reg[REG_ND_CONSUMABLE];
            REG_ND_WEAPON:     nd_cur = nd_reg[REG_ND_WEAPON];
            default:           nd_cur = '0;
        endcase
    end

    // Saturating append sum
    assign sum_ext = {1'b0, tot_cur} + (SUM_W + 1)'(weight_reg);
    assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign full    = (n_cur == CNT_FULL);

    assign app_go  = (req_reg == REQ_APPEND) && tbl_ok_reg && !full;
    assign draw_go = (req_reg == REQ_DRAW) && tbl_ok_reg && !(roll_reg < nd_cur) &&
                     (n_cur != '0) && (pick_reg < tot_cur);

    // Outcome of the checks
    always_comb
    begin
        ev_status = ST_OK;
        ev_total  = tot_cur;
        if (!tbl_ok_reg)
        begin
            ev_status = (req_reg == REQ_APPEND) ? ST_FULL : ST_EMPTY;
            ev_total  = '0;
        end
        else if (req_reg == REQ_APPEND)
        begin
            if (full)
            begin
                ev_status = ST_FULL;
            end
            else
            begin
                ev_total = sum_sat;
            end
        end
        else if (roll_reg < nd_cur)
        begin
            ev_status = ST_NODROP;
        end
        else if (!draw_go)
        begin
            ev_status = ST_EMPTY;
        end
    end

    // Bisect step: first entry whose sum exceeds the pick
    assign mid_first_full = n_cur >> 1;
    assign mid_first      = mid_first_full[IDX_W-1:0];
    assign rd_gt          = rd_data_reg > pick_reg;
    assign mid_inc        = CNT_W'(mid_reg) + CNT_W'(1);
    assign lo_n           = rd_gt ? lo_reg : mid_inc;
    assign hi_n           = rd_gt ? CNT_W'(mid_reg) : hi_reg;
    assign mid_sum        = (CNT_W + 1)'(lo_n) + (CNT_W + 1)'(hi_n);
    assign mid_n_full     = mid_sum[CNT_W:1];
    assign rd_mid         = cmd.step ? mid_n_full[IDX_W-1:0] : mid_first;

    assign sts.need_search = draw_go;
    assign sts.search_last = (lo_n == hi_n);

    // Memory ports
    assign mem_we  = cmd.eval && app_go;
    assign wr_addr = {tidx_reg, n_cur[IDX_W-1:0]};
    assign rd_addr = {tidx_reg, rd_mid};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sums_mem[wr_addr] <= sum_sat;
        end
        rd_data_reg <= sums_mem[rd_addr];
    end

    // Counts, totals and no-drop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                cnt_reg[i] <= '0;
                tot_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_REGS; i++)
            begin
                nd_reg[i] <= '0;
            end
        end
        else
        begin
            if (mem_we)
            begin
                cnt_reg[tidx_reg] <= n_cur + CNT_W'(1);
                tot_reg[tidx_reg] <= sum_sat;
            end
            if (cfg_we && (32'(cfg_index) < NUM_REGS))
            begin
                nd_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Item capture, search state and result staging
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= req_type;
            tsel_reg   <= table_select;
            tbl_ok_reg <= tbl_ok_in;
            tidx_reg   <= tbl_ok_in ? tsel_ext[TBL_W-1:0] : '0;
            weight_reg <= new_weight & WMASK;
            roll_reg   <= roll_percent;
            pick_reg   <= pick_value;
        end
        if (cmd.eval)
        begin
            lo_reg         <= '0;
            hi_reg         <= n_cur;
            mid_reg        <= mid_first;
            res_status_reg <= ev_status;
            res_index_reg  <= app_go ? n_cur[IDX_W-1:0] : '0;
            res_total_reg  <= ev_total;
        end
        if (cmd.step)
        begin
            lo_reg        <= lo_n;
            hi_reg        <= hi_n;
            mid_reg       <= rd_mid;
            res_index_reg <= lo_n[IDX_W-1:0];
        end
        if (cmd.load)
        begin
            status_reg <= res_status_reg;
            index_reg  <= idx_ext[EIDX_W-1:0];
            total_reg  <= res_total_reg;
        end
    end

    assign idx_ext = EXT_W'(res_index_reg);

    assign status       = status_reg;
    assign entry_index  = index_reg;
    assign total_weight = total_reg;

endmodule

/* sv/weighted_index_sampler.sv */
// Channel  Direction  Handshake            Payload
// in       in         in_valid / in_stall  req_type, table_select, new_weight,
//                                          roll_percent, pick_value
// out      out        out_valid/out_stall  status, entry_index, total_weight
// cfg      in         cfg_we               cfg_index, cfg_data
//
// One item at a time. An append, a failed check or a no-drop passes from transfer
// through the evaluate and done states to the result; a draw that searches also
// takes bisect steps for a table of n entries, one stored-sum read and compare per
// cycle on the single read port of the sums memory.
// Reset clears entry counts, totals and no-drop registers; the sums memory is
// not cleared. A held result stalls only the next result, not the next transfer.
module weighted_index_sampler #(
    parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF,
    parameter int NUM_TABLES  = wis_pkg::NUM_TABLES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [wis_pkg::TSEL_W-1:0]  table_select,
    input  logic [wis_pkg::WIN_W-1:0]   new_weight,
    input  logic [wis_pkg::PCT_W-1:0]   roll_percent,
    input  logic [wis_pkg::SUM_W-1:0]   pick_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [wis_pkg::STAT_W-1:0]  status,
    output logic [wis_pkg::EIDX_W-1:0]  entry_index,
    output logic [wis_pkg::SUM_W-1:0]   total_weight,
    input  logic                        cfg_we,
    input  logic [wis_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [wis_pkg::PCT_W-1:0]   cfg_data
);
    import wis_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    wis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Tables, search and result registers
    wis_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NUM_TABLES  (NUM_TABLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .table_select (table_select),
        .new_weight   (new_weight),
        .roll_percent (roll_percent),
        .pick_value   (pick_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .entry_index  (entry_index),
        .total_weight (total_weight)
    );

    // Only one item in flight: a transfer closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // Any non-ok result carries index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (entry_index == '0))
        else $error("non-ok result with nonzero entry index");

    // A load happens only from the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.capture && !cmd.eval && !cmd.step)
        else $error("result load overlaps other work");

endmodule

/* bench/sampler_check_pkg.sv */
package sampler_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import wis_pkg::*;

    // One input transfer, field for field
    typedef struct packed {
        logic              req;
        logic [TSEL_W-1:0] tsel;
        logic [WIN_W-1:0]  weight;
        logic [PCT_W-1:0]  roll;
        logic [SUM_W-1:0]  pick;
    } sample_req_t;

    // One result transfer
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [EIDX_W-1:0] index;
        logic [SUM_W-1:0]  total;
    } sample_res_t;

    localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};

    class sampler_scoreboard;
        logic [SUM_W-1:0] sums [NUM_TABLES_DEF][MAX_ENTRIES_DEF];
        int unsigned      counts [NUM_TABLES_DEF];
        logic [PCT_W-1:0] no_drop [NUM_REGS];
        sample_res_t      pending_results [$];
        int               errors;

        function new();
            foreach (counts[i]) counts[i] = 0;
            foreach (no_drop[i]) no_drop[i] = '0;
            errors = 0;
        endfunction

        // Indexes past the last register are dropped by the block
        function void set_no_drop(input logic [CIDX_W-1:0] idx, input logic [PCT_W-1:0] val);
            if (idx < NUM_REGS)
                no_drop[idx] = val;
        endfunction

        function logic [SUM_W-1:0] table_total(input int unsigned t);
            if (t >= NUM_TABLES_DEF || counts[t] == 0)
                return '0;
            return sums[t][counts[t] - 1];
        endfunction

        // Update the sum tables and queue the outcome of one accepted request
        function void note_request(input sample_req_t r);
            sample_res_t      res;
            int unsigned      t;
            int unsigned      n;
            int unsigned      lo;
            int unsigned      hi;
            int unsigned      mid;
            logic [SUM_W:0]   grown;
            logic [PCT_W-1:0] pct;

            t   = 32'(r.tsel);
            res = '0;
            if (t >= NUM_TABLES_DEF) begin
                // table with no capacity at all
                res.status = (r.req == REQ_APPEND) ? ST_FULL : ST_EMPTY;
            end
            else begin
                n         = counts[t];
                res.total = table_total(t);
                if (r.req == REQ_APPEND) begin
                    if (n >= MAX_ENTRIES_DEF) begin
                        res.status = ST_FULL;
                    end
                    else begin
                        grown        = {1'b0, res.total} + (SUM_W + 1)'(r.weight);
                        sums[t][n]   = grown[SUM_W] ? SUM_CEIL : grown[SUM_W-1:0];
                        counts[t]    = n + 1;
                        res.status   = ST_OK;
                        res.index    = n[EIDX_W-1:0];
                        res.total    = sums[t][n];
                    end
                end
                else begin
                    pct = (t < NUM_REGS) ? no_drop[t] : '0;
                    if (r.roll < pct) begin
                        res.status = ST_NODROP;
                    end
                    else if (n == 0 || r.pick >= res.total) begin
                        res.status = ST_EMPTY;
                    end
                    else begin
                        // first entry whose running sum exceeds the pick
                        lo = 0;
                        hi = n;
                        while (lo < hi) begin
                            mid = (lo + hi) / 2;
                            if (sums[t][mid] > r.pick)
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        res.status = ST_OK;
                        res.index  = lo[EIDX_W-1:0];
                    end
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(input sample_res_t got);
            sample_res_t want;

            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d index %0d total %0d",
                         $time, got.status, got.index, got.total);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.index !== want.index) begin
                $display("%0t: entry_index expected %0d, got %0d", $time, want.index, got.index);
                errors++;
            end
            if (got.total !== want.total) begin
                $display("%0t: total_weight expected %0d, got %0d", $time, want.total, got.total);
                errors++;
            end
        endfunction
    endclass

endpackage

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wis_pkg::*;
    import sampler_check_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 12;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              req_type     = REQ_APPEND;
    logic [TSEL_W-1:0] table_select = '0;
    logic [WIN_W-1:0]  new_weight   = '0;
    logic [PCT_W-1:0]  roll_percent = '0;
    logic [SUM_W-1:0]  pick_value   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [STAT_W-1:0] status;
    logic [EIDX_W-1:0] entry_index;
    logic [SUM_W-1:0]  total_weight;
    logic              cfg_we       = 1'b0;
    logic [CIDX_W-1:0] cfg_index    = '0;
    logic [PCT_W-1:0]  cfg_data     = '0;

    // Idling control shared by both sides
    logic calm       = 1'b0;
    logic hold_token = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    sampler_scoreboard sb;

    weighted_index_sampler uut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            sb.check_result({status, entry_index, total_weight});
    end

    // Present one request and hold it until the transfer
    task automatic send_request(input sample_req_t r);
        in_valid     <= 1'b1;
        req_type     <= r.req;
        table_select <= r.tsel;
        new_weight   <= r.weight;
        roll_percent <= r.roll;
        pick_value   <= r.pick;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(r);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic issue(input logic rq, input int tbl, input int wt, input int rl, input int pk);
        sample_req_t r;
        r.req    = rq;
        r.tsel   = TSEL_W'(tbl);
        r.weight = WIN_W'(wt);
        r.roll   = PCT_W'(rl);
        r.pick   = SUM_W'(pk);
        send_request(r);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write all three no-drop registers, then the unused index
    task automatic program_no_drop(input logic [PCT_W-1:0] mat, input logic [PCT_W-1:0] con,
                                   input logic [PCT_W-1:0] wpn, input logic [PCT_W-1:0] junk);
        logic [PCT_W-1:0] vals [NUM_REGS+1];
        vals[REG_ND_MATERIAL]   = mat;
        vals[REG_ND_CONSUMABLE] = con;
        vals[REG_ND_WEAPON]     = wpn;
        vals[NUM_REGS]          = junk;
        cfg_we <= 1'b1;
        for (int i = 0; i <= NUM_REGS; i++) begin
            cfg_index <= CIDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_no_drop(CIDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // A mix of appends and draws, mostly with in-range picks, with some junk mixed in
    function automatic sample_req_t random_request();
        sample_req_t      r;
        int unsigned      roll_tbl;
        int unsigned      pick_kind;
        logic [SUM_W-1:0] tot;

        r.req    = ($urandom_range(0, 99) < 45) ? REQ_APPEND : REQ_DRAW;
        roll_tbl = $urandom_range(0, 99);
        if (roll_tbl < 3)
            r.tsel = TSEL_W'(NUM_TABLES_DEF);
        else if (roll_tbl < 50)
            r.tsel = '0;
        else
            r.tsel = TSEL_W'($urandom_range(1, NUM_TABLES_DEF - 1));
        case ($urandom_range(0, 9))
            0:          r.weight = '0;
            1:          r.weight = '1;
            2, 3, 4, 5: r.weight = WIN_W'($urandom_range(1, 255));
            default:    r.weight = WIN_W'($urandom);
        endcase
        r.roll    = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
        tot       = sb.table_total(32'(r.tsel));
        pick_kind = $urandom_range(0, 99);
        if (pick_kind < 75 && tot != 0)
            r.pick = SUM_W'($urandom_range(0, 32'(tot) - 1));
        else if (pick_kind < 85)
            r.pick = SUM_W'(32'(tot) - $urandom_range(0, 1));
        else
            r.pick = SUM_W'($urandom_range(0, 32'(SUM_CEIL)));
        return r;
    endfunction

    task automatic run_batch(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 2)
                hold_token <= ~hold_token;
            send_request(random_request());
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tables, missing table, zero weight, pick edges
        issue(REQ_DRAW, 0, 0, 0, 0);
        issue(REQ_DRAW, 1, 0, 127, 24'hFFFFFF);
        issue(REQ_APPEND, 3, 16'hFFFF, 0, 0);
        issue(REQ_DRAW, 3, 0, 0, 0);
        issue(REQ_APPEND, 0, 0, 0, 0);
        issue(REQ_DRAW, 0, 0, 0, 0);
        issue(REQ_APPEND, 0, 16'hFFFF, 0, 0);
        issue(REQ_APPEND, 0, 1, 0, 0);
        issue(REQ_DRAW, 0, 0, 0, 0);
        issue(REQ_DRAW, 0, 0, 0, 24'h00FFFE);
        issue(REQ_DRAW, 0, 0, 0, 24'h00FFFF);
        issue(REQ_DRAW, 0, 0, 0, 24'h010000);
        issue(REQ_DRAW, 0, 0, 99, 24'hFFFFFF);
        issue(REQ_APPEND, 1, 5, 0, 0);
        issue(REQ_APPEND, 2, 16'hFFFF, 0, 0);
        issue(REQ_DRAW, 1, 0, 99, 4);
        issue(REQ_DRAW, 2, 0, 0, 0);

        // No-drop at full strength; missing table has no register
        drain();
        program_no_drop(7'd100, 7'd100, 7'd100, 7'h7F);
        issue(REQ_DRAW, 0, 0, 99, 0);
        issue(REQ_DRAW, 0, 0, 100, 0);
        issue(REQ_DRAW, 3, 0, 0, 0);
        issue(REQ_DRAW, 1, 0, 0, 24'hFFFFFF);

        // Raw percent above 100
        drain();
        program_no_drop(7'h7F, 7'd0, 7'd50, 7'd0);
        issue(REQ_DRAW, 0, 0, 126, 0);
        issue(REQ_DRAW, 1, 0, 127, 24'hFFFFFF);

        // Random phases over several register settings
        drain();
        program_no_drop(7'd0, 7'd0, 7'd0, PCT_W'($urandom));
        calm <= 1'b1;
        run_batch(300, 1'b0);
        calm <= 1'b0;

        drain();
        program_no_drop(PCT_W'($urandom_range(0, 30)), PCT_W'($urandom_range(0, 30)),
                        PCT_W'($urandom_range(0, 30)), PCT_W'($urandom));
        run_batch(400, 1'b1);

        drain();
        program_no_drop(7'd100, 7'h7F, 7'd0, PCT_W'($urandom));
        run_batch(250, 1'b0);

        drain();
        program_no_drop(PCT_W'($urandom), PCT_W'($urandom), PCT_W'($urandom),
                        PCT_W'($urandom));
        run_batch(400, 1'b1);

        drain();
        program_no_drop(7'd0, 7'd5, 7'd10, PCT_W'($urandom));
        run_batch(350, 1'b0);

        drain();
        program_no_drop(PCT_W'($urandom_range(0, 20)), PCT_W'($urandom_range(0, 20)),
                        PCT_W'($urandom_range(0, 20)), PCT_W'($urandom));
        run_batch(300, 1'b0);

        // Let any stray result show up before the verdict
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
sv/wis_pkg.sv
sv/wis_ctrl.sv
sv/wis_dp.sv
sv/weighted_index_sampler.sv
bench/sampler_check_pkg.sv
bench/testbench.sv
